// ===== hw/rtl/rmjd_pkg.sv =====
// shared types and codes for the rate-monotonic job dispatcher
package rmjd_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_DISP  = 2'd2,
    MODE_RUN   = 2'd3
  } mode_e;

  typedef enum logic {
    REG_TASK_COUNT = 1'b0,
    REG_PRIO_MAP   = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_INIT  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  localparam logic [3:0]  TASK_COUNT_RST = 4'd8;
  localparam logic [23:0] PRIO_MAP_RST   = 24'hFAC688;

  typedef struct packed {
    logic [2:0]  task_id;
    logic [15:0] remaining;
    logic [31:0] deadline;
  } entry_t;

  typedef struct packed {
    entry_t      entry;
    logic        init;
    logic        step;
    logic        chk_deadline;
    logic [31:0] clock;
    logic        run;
  } ctrl_t;

  typedef struct packed {
    logic       found;
    entry_t     entry;
    logic [5:0] misses;
  } chain_t;

endpackage

// ===== hw/rtl/rmjd_cell.sv =====
// one priority level: job queue in flops, rotating compaction pass, chain link
module rmjd_cell #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmjd_pkg::ctrl_t     ctrl_i,
  input  logic                en_i,
  input  logic                push_i,
  input  rmjd_pkg::chain_t    chain_i,
  output rmjd_pkg::chain_t    chain_o,
  output logic                full_o
);

  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  rmjd_pkg::entry_t q_q [QUEUE_DEPTH];
  rmjd_pkg::entry_t q_d [QUEUE_DEPTH];
  logic [FW-1:0] fill_q, fill_d, left_q, left_d, miss_q, miss_d;
  logic [FW-1:0] last;
  rmjd_pkg::entry_t head;
  logic [31:0] diff;
  logic drop, stepping, ready_here, run;

  assign head       = q_q[0];
  assign diff       = head.deadline - ctrl_i.clock;
  assign drop       = ctrl_i.chk_deadline ? (diff[31] || (diff < {16'b0, head.remaining}))
                                          : (head.remaining == 16'd0);
  assign stepping   = ctrl_i.step && (left_q != '0);
  assign ready_here = en_i && (fill_q != '0);
  assign run        = ctrl_i.run && ready_here && !chain_i.found;
  assign last       = fill_q - FW'(1);
  assign full_o     = (fill_q == FW'(QUEUE_DEPTH));

  always_comb begin
    q_d    = q_q;
    fill_d = fill_q;
    left_d = left_q;
    miss_d = miss_q;
    if (ctrl_i.init) begin
      left_d = en_i ? fill_q : '0;
      miss_d = '0;
    end
    if (push_i && !full_o) begin
      q_d[fill_q[IW-1:0]] = ctrl_i.entry;
      fill_d = fill_q + FW'(1);
    end
    if (run && head.remaining != 16'd0) begin
      q_d[0].remaining = head.remaining - 16'd1;
    end
    if (stepping) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        q_d[j] = q_q[j+1];
      end
      left_d = left_q - FW'(1);
      if (drop) begin
        fill_d = fill_q - FW'(1);
        miss_d = miss_q + FW'(1);
      end else begin
        q_d[last[IW-1:0]] = head;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      left_q <= '0;
      miss_q <= '0;
    end else begin
      fill_q <= fill_d;
      left_q <= left_d;
      miss_q <= miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_comb begin
    chain_o.found  = chain_i.found | ready_here;
    chain_o.entry  = chain_i.found ? chain_i.entry : (ready_here ? head : '0);
    chain_o.misses = chain_i.misses + 6'(miss_q);
  end

endmodule

// ===== hw/rtl/rate_monotonic_job_dispatcher.sv =====
// top level: config registers, sequencer, chain of priority-level cells
//
//  port group  | direction | handshake
//  ------------+-----------+-------------------------------
//  in word     | in        | in_valid_i / in_stall_o
//  out word    | out       | out_valid_o / out_stall_i
//  config      | in/out    | apb psel/penable/pready
//
// push and run results are registered in the cycle after the word; check and
// dispatch pass init, a rotating compaction sweep of every enabled cell, and done
// a new word is taken only once the previous result has been taken
// reset empties every queue and loads the default register values
// a stalled result holds its output register
module rate_monotonic_job_dispatcher #(
  parameter int MAX_TASKS   = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  task_id_i,
  input  logic [15:0] exec_time_i,
  input  logic [31:0] abs_deadline_i,
  input  logic [31:0] clock_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  job_task_id_o,
  output logic [15:0] job_remaining_o,
  output logic [31:0] job_deadline_o,
  output logic        idle_o,
  output logic [5:0]  miss_count_o,
  output logic        overflow_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [3:0]  task_count_q;
  logic [23:0] prio_map_q;
  logic [3:0]  levels;
  rmjd_pkg::state_e state_q, state_d;
  logic [FW-1:0] sweep_q, sweep_d;
  logic          chk_q;
  logic [31:0]   clock_q;
  logic          accept, out_take;
  logic [2:0]    lvl;
  logic          tgt_ok;
  logic [MAX_TASKS-1:0] full, push_vec, en_vec;
  rmjd_pkg::chain_t chain [MAX_TASKS+1];
  rmjd_pkg::ctrl_t  ctrl;
  rmjd_pkg::mode_e  mode;
  rmjd_pkg::entry_t run_entry;

  logic        out_valid_q;
  rmjd_pkg::entry_t out_entry_q;
  logic        idle_q, ovf_q;
  logic [5:0]  miss_q;

  assign pready = 1'b1;
  assign mode   = rmjd_pkg::mode_e'(mode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= rmjd_pkg::TASK_COUNT_RST;
      prio_map_q   <= rmjd_pkg::PRIO_MAP_RST;
    end else if (psel && penable && pwrite) begin
      case (rmjd_pkg::reg_idx_e'(paddr[2]))
        rmjd_pkg::REG_TASK_COUNT: task_count_q <= pwdata[3:0];
        rmjd_pkg::REG_PRIO_MAP:   prio_map_q   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rmjd_pkg::reg_idx_e'(paddr[2]))
      rmjd_pkg::REG_TASK_COUNT: prdata = {28'b0, task_count_q};
      rmjd_pkg::REG_PRIO_MAP:   prdata = {8'b0, prio_map_q};
      default:                  prdata = '0;
    endcase
  end

  assign levels = (task_count_q > 4'(MAX_TASKS)) ? 4'(MAX_TASKS) : task_count_q;

  assign in_stall_o = !(state_q == rmjd_pkg::S_IDLE && !out_valid_q);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  assign lvl    = prio_map_q[3*task_id_i +: 3];
  assign tgt_ok = ({1'b0, task_id_i} < levels) && ({1'b0, lvl} < levels);

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      en_vec[i]   = (4'(i) < levels);
      push_vec[i] = accept && (mode == rmjd_pkg::MODE_PUSH) && tgt_ok
                    && (lvl[LW-1:0] == LW'(i));
    end
  end

  always_comb begin
    ctrl.entry        = '{task_id: task_id_i, remaining: exec_time_i, deadline: abs_deadline_i};
    ctrl.init         = (state_q == rmjd_pkg::S_INIT);
    ctrl.step         = (state_q == rmjd_pkg::S_SWEEP);
    ctrl.chk_deadline = chk_q;
    ctrl.clock        = clock_q;
    ctrl.run          = accept && (mode == rmjd_pkg::MODE_RUN);
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    rmjd_cell #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .en_i    (en_vec[g]),
      .push_i  (push_vec[g]),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .full_o  (full[g])
    );
  end

  always_comb begin
    run_entry = chain[MAX_TASKS].entry;
    if (run_entry.remaining != 16'd0) begin
      run_entry.remaining = run_entry.remaining - 16'd1;
    end
  end

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    case (state_q)
      rmjd_pkg::S_IDLE: begin
        if (accept && (mode == rmjd_pkg::MODE_CHECK || mode == rmjd_pkg::MODE_DISP)) begin
          state_d = rmjd_pkg::S_INIT;
        end
      end
      rmjd_pkg::S_INIT: begin
        state_d = rmjd_pkg::S_SWEEP;
        sweep_d = FW'(QUEUE_DEPTH);
      end
      rmjd_pkg::S_SWEEP: begin
        sweep_d = sweep_q - FW'(1);
        if (sweep_q == FW'(1)) begin
          state_d = rmjd_pkg::S_DONE;
        end
      end
      rmjd_pkg::S_DONE: state_d = rmjd_pkg::S_IDLE;
      default:          state_d = rmjd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmjd_pkg::S_IDLE;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      chk_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      if (accept) begin
        chk_q <= (mode == rmjd_pkg::MODE_CHECK);
      end
      if (accept && (mode == rmjd_pkg::MODE_PUSH || mode == rmjd_pkg::MODE_RUN)) begin
        out_valid_q <= 1'b1;
      end else if (state_q == rmjd_pkg::S_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      clock_q <= clock_req_i;
    end
    if (accept && mode == rmjd_pkg::MODE_PUSH) begin
      out_entry_q <= '0;
      idle_q      <= 1'b0;
      miss_q      <= '0;
      ovf_q       <= tgt_ok && full[lvl[LW-1:0]];
    end else if (accept && mode == rmjd_pkg::MODE_RUN) begin
      out_entry_q <= run_entry;
      idle_q      <= !chain[MAX_TASKS].found;
      miss_q      <= '0;
      ovf_q       <= 1'b0;
    end else if (state_q == rmjd_pkg::S_DONE) begin
      ovf_q <= 1'b0;
      if (chk_q) begin
        out_entry_q <= '0;
        idle_q      <= 1'b0;
        miss_q      <= chain[MAX_TASKS].misses;
      end else begin
        out_entry_q <= chain[MAX_TASKS].entry;
        idle_q      <= !chain[MAX_TASKS].found;
        miss_q      <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign job_task_id_o   = out_entry_q.task_id;
  assign job_remaining_o = out_entry_q.remaining;
  assign job_deadline_o  = out_entry_q.deadline;
  assign idle_o          = idle_q;
  assign miss_count_o    = miss_q;
  assign overflow_o      = ovf_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

  a_valid_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == rmjd_pkg::S_IDLE) else $error("result pending outside idle");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rmjd_pkg::S_SWEEP |-> (sweep_q != '0 && sweep_q <= FW'(QUEUE_DEPTH)))
    else $error("sweep counter out of range");

  a_done_follows_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rmjd_pkg::S_DONE |-> $past(state_q) == rmjd_pkg::S_SWEEP)
    else $error("done without sweep");

endmodule
